// ===== hdl/mfsb_pkg.sv =====
// Shared types, codes and constants for the MFM flux sync bitstream block.
// No dependencies; every other file imports this package.
package mfsb_pkg;

   localparam int CountWidth    = 16;
   localparam int FifoDepth     = 4;
   localparam int FifoPtrWidth  = $clog2(FifoDepth);
   localparam int HistDepth     = 11;
   localparam int HistIdxWidth  = $clog2(HistDepth);
   localparam int SeenWidth     = $clog2(HistDepth + 1);
   localparam int SyncLen       = 10;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   localparam logic [15:0] MidThreshReset  = 16'd500;
   localparam logic [15:0] LongThreshReset = 16'd700;
   localparam logic [15:0] MaxBytesReset   = 16'd11964;

   localparam logic [1:0] KIND_FLUX      = 2'd0;
   localparam logic [1:0] KIND_RESTART   = 2'd1;
   localparam logic [1:0] KIND_TRACK_END = 2'd2;

   localparam logic [1:0] STAT_BYTE      = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_TRACK_END = 2'd2;
   localparam logic [1:0] STAT_NO_SYNC   = 2'd3;

   localparam logic [CsrIndexWidth-1:0] CSR_MID_THRESHOLD  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LONG_THRESHOLD = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_BYTES      = 2'd2;

   // cell class is cells minus one: 1 = two cells, 2 = three, 3 = four
   localparam logic [1:0] SyncClass [SyncLen] = '{
      2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1
   };

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] flux_interval;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last;
      logic [1:0]  status;
      logic [15:0] samples_used;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] mid_threshold;
      logic [15:0] long_threshold;
      logic [15:0] max_bytes;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_FLUX      = 2'd0,
      OP_RESTART   = 2'd1,
      OP_TRACK_END = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [1:0] cls;
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_HUNT = 3'b001,
      MODE_RUN  = 3'b010,
      MODE_DONE = 3'b100
   } mode_type;

   typedef enum logic [1:0] {
      SEQ_IDLE   = 2'b01,
      SEQ_REPLAY = 2'b10
   } seq_type;

endpackage

// ===== hdl/mfsb_front.sv =====
// Front end: accepts input transactions, sorts flux samples into cell classes.
// Depends on mfsb_pkg; feeds the command queue.
module mfsb_front
   import mfsb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            push_valid,
   output cmd_type         push_cmd,
   input  logic            push_ready
);

   logic    cmd_valid_ff, cmd_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;
   logic    keep;

   assign req_stall  = cmd_valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = cmd_valid_ff;
   assign push_cmd   = cmd_ff;

   always_comb begin
      keep   = 1'b1;
      cmd_in = cmd_ff;
      unique case (req_payload.kind)
         KIND_FLUX: begin
            cmd_in.op = OP_FLUX;
         end
         KIND_RESTART: begin
            cmd_in.op = OP_RESTART;
         end
         KIND_TRACK_END: begin
            cmd_in.op = OP_TRACK_END;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      if (req_payload.flux_interval > cfg.long_threshold) begin
         cmd_in.cls = 2'd3;
      end else if (req_payload.flux_interval > cfg.mid_threshold) begin
         cmd_in.cls = 2'd2;
      end else begin
         cmd_in.cls = 2'd1;
      end
      if (accept && keep) begin
         cmd_valid_in = 1'b1;
      end else if (push_ready) begin
         cmd_valid_in = 1'b0;
      end else begin
         cmd_valid_in = cmd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== hdl/mfsb_cmd_fifo.sv =====
// Short command queue between the front end and the decode engine.
// Depends on mfsb_pkg.
module mfsb_cmd_fifo
   import mfsb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop_ready
);

   cmd_type                 mem_ff [FifoDepth];
   logic [FifoPtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FifoPtrWidth:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = (count_ff != (FifoPtrWidth+1)'(FifoDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/mfsb_engine.sv =====
// Decode engine: sync hunt, sample replay, bit placement and byte output.
// Depends on mfsb_pkg; drains the command queue, drives the result register.
module mfsb_engine
   import mfsb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            pop_valid,
   input  cmd_type         pop_cmd,
   output logic            pop_ready,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic [1:0]              hist_ff [HistDepth];
   logic [1:0]              hist_in [HistDepth];
   logic [1:0]              hist_shift [HistDepth];
   logic [SeenWidth-1:0]    seen_ff, seen_in, seen_next;
   mode_type                mode_ff, mode_in;
   seq_type                 seq_ff, seq_in;
   logic [HistIdxWidth-1:0] idx_ff, idx_in;
   logic [2:0]              off_ff, off_in;
   logic [7:0]              acc_ff, acc_in;
   logic [15:0]             bytes_ff, bytes_in;
   logic [CountWidth-1:0]   cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_payload_ff, rsp_payload_in;

   logic                    out_free;
   logic                    replaying;
   logic                    take;
   logic                    match;
   logic [1:0]              rep_cls;
   logic [2:0]              adv;
   logic [3:0]              pos;
   logic                    crossed;
   logic [15:0]             bytes_next;
   logic [CountWidth-1:0]   cnt_next;
   logic                    full;
   logic [15:0]             used_now;
   logic [15:0]             used_next;
   logic [7:0]              acc_next;
   logic                    do_adv;

   function automatic logic [15:0] sat_used(input logic [CountWidth-1:0] c);
      logic [32:0] e;
      e = 33'(c);
      return (e > 33'h0FFFF) ? 16'hFFFF : e[15:0];
   endfunction

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign replaying   = (seq_ff == SEQ_REPLAY);
   assign pop_ready   = !replaying && out_free;
   assign take        = pop_valid && pop_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      for (int k = 0; k < HistDepth - 1; k++) begin
         hist_shift[k] = hist_ff[k+1];
      end
      hist_shift[HistDepth-1] = pop_cmd.cls;
      match = 1'b1;
      for (int k = 0; k < SyncLen; k++) begin
         if (hist_shift[k+1] != SyncClass[k]) begin
            match = 1'b0;
         end
      end
      seen_next = (seen_ff == SeenWidth'(HistDepth)) ? seen_ff : seen_ff + 1'b1;
   end

   always_comb begin
      rep_cls = hist_ff[idx_ff];
      if (replaying) begin
         adv = (idx_ff == '0) ? 3'({1'b0, rep_cls}) - 3'd1 : 3'({1'b0, rep_cls}) + 3'd1;
      end else begin
         adv = 3'({1'b0, pop_cmd.cls}) + 3'd1;
      end
      pos        = {1'b0, off_ff} + {1'b0, adv};
      crossed    = pos[3];
      bytes_next = crossed ? bytes_ff + 16'd1 : bytes_ff;
      cnt_next   = (cnt_ff != '1) ? cnt_ff + 1'b1 : cnt_ff;
      full       = (bytes_next >= cfg.max_bytes);
      used_now   = sat_used(cnt_ff);
      used_next  = sat_used(cnt_next);
      acc_next   = (crossed ? 8'd0 : acc_ff) | (8'h80 >> pos[2:0]);
   end

   always_comb begin
      hist_in        = hist_ff;
      seen_in        = seen_ff;
      mode_in        = mode_ff;
      seq_in         = seq_ff;
      idx_in         = idx_ff;
      off_in         = off_ff;
      acc_in         = acc_ff;
      bytes_in       = bytes_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      do_adv         = 1'b0;

      if (replaying && out_free) begin
         do_adv = 1'b1;
         idx_in = idx_ff + 1'b1;
         if (idx_ff == HistIdxWidth'(HistDepth - 1)) begin
            seq_in = SEQ_IDLE;
         end
      end else if (take) begin
         unique case (pop_cmd.op)
            OP_FLUX: begin
               if (mode_ff == MODE_RUN) begin
                  do_adv = 1'b1;
               end else if (mode_ff == MODE_HUNT) begin
                  hist_in = hist_shift;
                  seen_in = seen_next;
                  if (seen_next == SeenWidth'(HistDepth) && match) begin
                     mode_in  = MODE_RUN;
                     seq_in   = SEQ_REPLAY;
                     idx_in   = '0;
                     off_in   = '0;
                     acc_in   = '0;
                     bytes_in = '0;
                     cnt_in   = '0;
                  end
               end
            end
            OP_RESTART, OP_TRACK_END: begin
               if (pop_cmd.op == OP_TRACK_END && mode_ff == MODE_RUN) begin
                  rsp_valid_in   = 1'b1;
                  rsp_payload_in = '{data_byte: acc_ff, last: 1'b1,
                                     status: STAT_TRACK_END, samples_used: used_now};
               end else if (pop_cmd.op == OP_TRACK_END && mode_ff == MODE_HUNT) begin
                  rsp_valid_in   = 1'b1;
                  rsp_payload_in = '{data_byte: 8'd0, last: 1'b1,
                                     status: STAT_NO_SYNC, samples_used: 16'd0};
               end
               for (int k = 0; k < HistDepth; k++) begin
                  hist_in[k] = 2'd0;
               end
               seen_in  = '0;
               mode_in  = MODE_HUNT;
               off_in   = '0;
               acc_in   = '0;
               bytes_in = '0;
               cnt_in   = '0;
            end
            default: begin
            end
         endcase
      end

      if (do_adv) begin
         cnt_in   = cnt_next;
         bytes_in = bytes_next;
         off_in   = pos[2:0];
         if (crossed) begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = '{data_byte: acc_ff, last: full,
                               status: full ? STAT_FULL : STAT_BYTE,
                               samples_used: full ? used_next : 16'd0};
         end else if (full) begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = '{data_byte: 8'd0, last: 1'b1,
                               status: STAT_FULL, samples_used: used_next};
         end
         if (full) begin
            mode_in = MODE_DONE;
            seq_in  = SEQ_IDLE;
            acc_in  = '0;
         end else begin
            acc_in = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HistDepth; k++) begin
            hist_ff[k] <= 2'd0;
         end
         seen_ff      <= '0;
         mode_ff      <= MODE_HUNT;
         seq_ff       <= SEQ_IDLE;
         idx_ff       <= '0;
         off_ff       <= '0;
         acc_ff       <= '0;
         bytes_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_ff      <= hist_in;
         seen_ff      <= seen_in;
         mode_ff      <= mode_in;
         seq_ff       <= seq_in;
         idx_ff       <= idx_in;
         off_ff       <= off_in;
         acc_ff       <= acc_in;
         bytes_ff     <= bytes_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// ===== hdl/mfm_flux_sync_bitstream_top.sv =====
// Top level of the MFM flux decoder with double sync word hunt.
// Depends on mfsb_pkg, mfsb_front, mfsb_cmd_fifo and mfsb_engine.
//
//   channel   ports                                  direction
//   req       req_valid, req_stall, req_payload      flux samples and track commands in
//   rsp       rsp_valid, rsp_stall, rsp_payload      decoded bytes and run status out
//   csr       csr_write_en, csr_index, csr_wdata     threshold and byte limit writes
//
// The front end takes one transaction per cycle, unless stalled, into a four-entry
// command queue. The engine retires one command per cycle while the result register
// is free; on a sync match it first replays the 11 history samples, one per cycle.
// A stalled result register holds the engine; the queue absorbs input until full.
// Reset is synchronous; it clears the control state and loads the reset configuration.
module mfm_flux_sync_bitstream_top
   import mfsb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_payload_type          req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_payload_type          rsp_payload,
   input  logic                     csr_write_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MID_THRESHOLD: begin
               cfg_in.mid_threshold = csr_wdata;
            end
            CSR_LONG_THRESHOLD: begin
               cfg_in.long_threshold = csr_wdata;
            end
            CSR_MAX_BYTES: begin
               cfg_in.max_bytes = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mid_threshold: MidThreshReset, long_threshold: LongThreshReset,
                     max_bytes: MaxBytesReset};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mfsb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd),
      .push_ready  (push_ready)
   );

   mfsb_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   mfsb_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop_valid   (pop_valid),
      .pop_cmd     (pop_cmd),
      .pop_ready   (pop_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hdl/mfsb_checker.sv =====
// Port-level checks on the result channel of the MFM flux sync block.
// Depends on mfsb_pkg; bound to mfm_flux_sync_bitstream_top.
module mfsb_checker
   import mfsb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last == (rsp_payload.status != STAT_BYTE)))
      else $error("last flag disagrees with status");

   a_used_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> rsp_payload.samples_used == 16'd0)
      else $error("sample count on a mid-run byte");

   a_no_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STAT_NO_SYNC
         |-> rsp_payload.data_byte == 8'd0 && rsp_payload.samples_used == 16'd0)
      else $error("no-sync result carries data");

endmodule

bind mfm_flux_sync_bitstream_top mfsb_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== dv/mfm_flux_sync_bitstream_top_tb.sv =====
// Testbench for mfm_flux_sync_bitstream_top: directed rows, then random sync runs per threshold set.
// Checks each result transaction against an in-bench MFM decoder with the double sync hunt.
// Depends on mfsb_pkg and the RTL under hdl.
module mfm_flux_sync_bitstream_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mfsb_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 64;
   localparam int HoldCycles  = 300;
   localparam logic [1:0] KindUnused = 2'd3;

   localparam rsp_payload_type NoSyncEnd = '{8'h00, 1'b1, STAT_NO_SYNC, 16'd0};
   localparam rsp_payload_type NoCheck   = '0;

   typedef struct packed {
      logic [1:0]      kind;
      logic [15:0]     flux;
      logic            typed;
      rsp_payload_type want;
   } directed_row_type;

   localparam int NumDirected = 22;
   localparam directed_row_type DirectedRows [NumDirected] = '{
      '{KIND_TRACK_END, 16'h0000, 1'b1, NoSyncEnd},
      '{KIND_TRACK_END, 16'hFFFF, 1'b1, NoSyncEnd},
      '{KindUnused,     16'hFFFF, 1'b0, NoCheck},
      '{KIND_FLUX,      16'd500,  1'b0, NoCheck},
      '{KIND_FLUX,      16'd701,  1'b0, NoCheck},
      '{KIND_FLUX,      16'd700,  1'b0, NoCheck},
      '{KIND_FLUX,      16'hFFFF, 1'b0, NoCheck},
      '{KIND_FLUX,      16'd501,  1'b0, NoCheck},
      '{KIND_FLUX,      16'd0,    1'b0, NoCheck},
      '{KIND_FLUX,      16'd701,  1'b0, NoCheck},
      '{KIND_FLUX,      16'd600,  1'b0, NoCheck},
      '{KIND_FLUX,      16'd800,  1'b0, NoCheck},
      '{KIND_FLUX,      16'd650,  1'b0, NoCheck},
      '{KIND_FLUX,      16'd500,  1'b0, NoCheck},
      '{KIND_FLUX,      16'hFFFF, 1'b0, NoCheck},
      '{KIND_FLUX,      16'd0,    1'b0, NoCheck},
      '{KindUnused,     16'h0000, 1'b0, NoCheck},
      '{KIND_FLUX,      16'd600,  1'b0, NoCheck},
      '{KIND_TRACK_END, 16'h0000, 1'b0, NoCheck},
      '{KIND_RESTART,   16'h0000, 1'b0, NoCheck},
      '{KIND_FLUX,      16'd1234, 1'b0, NoCheck},
      '{KIND_TRACK_END, 16'h0000, 1'b1, NoSyncEnd}
   };

   logic                     clock;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   req_payload_type          req_payload  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   rsp_payload_type          rsp_payload;
   logic                     csr_write_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index    = '0;
   logic [CsrDataWidth-1:0]  csr_wdata    = '0;

   mfm_flux_sync_bitstream_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   cfg_type         thr_cfg;
   logic [1:0]      hist_cls [HistDepth];
   int              hist_seen;
   mode_type        run_mode;
   logic [2:0]      bit_pos;
   logic [7:0]      byte_acc;
   logic [15:0]     emitted_bytes;
   logic [15:0]     used_count;

   rsp_payload_type step_decoded [$];
   rsp_payload_type pending_decoded [$];
   req_payload_type flux_items [$];
   int              flux_item_count;

   int mismatches   = 0;
   int cycle_count  = 0;
   bit rsp_hold_req = 1'b0;
   bit req_no_gaps  = 1'b0;
   bit rsp_no_gaps  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   function automatic int cells_of(input logic [15:0] flux);
      if (flux > thr_cfg.long_threshold) return 4;
      if (flux > thr_cfg.mid_threshold) return 3;
      return 2;
   endfunction

   task automatic clear_track();
      int k;
      for (k = 0; k < HistDepth; k++) hist_cls[k] = '0;
      hist_seen     = 0;
      run_mode      = MODE_HUNT;
      bit_pos       = '0;
      byte_acc      = '0;
      emitted_bytes = '0;
      used_count    = '0;
   endtask

   task automatic place_cells(input int adv, output bit ended);
      int pos;
      bit crossed;
      rsp_payload_type r;
      ended   = 1'b0;
      crossed = 1'b0;
      pos     = int'(bit_pos) + adv;
      if (used_count != 16'hFFFF) used_count++;
      if (pos >= 8) begin
         pos -= 8;
         r = '{byte_acc, 1'b0, STAT_BYTE, 16'd0};
         step_decoded.push_back(r);
         emitted_bytes++;
         byte_acc = '0;
         crossed  = 1'b1;
      end
      bit_pos = pos[2:0];
      if (emitted_bytes >= thr_cfg.max_bytes) begin
         if (crossed) begin
            r = step_decoded.pop_back();
            r.last         = 1'b1;
            r.status       = STAT_FULL;
            r.samples_used = used_count;
         end else begin
            r = '{8'h00, 1'b1, STAT_FULL, used_count};
         end
         step_decoded.push_back(r);
         run_mode = MODE_DONE;
         ended    = 1'b1;
      end else begin
         byte_acc = byte_acc | (8'h80 >> bit_pos);
      end
   endtask

   task automatic start_sync_replay();
      int k;
      int c;
      bit ended;
      run_mode      = MODE_RUN;
      bit_pos       = '0;
      byte_acc      = '0;
      emitted_bytes = '0;
      used_count    = '0;
      ended         = 1'b0;
      for (k = 0; k < HistDepth && !ended; k++) begin
         c = int'(hist_cls[k]) + 1;
         place_cells((k == 0) ? c - 2 : c, ended);
      end
   endtask

   task automatic decode_flux(input req_payload_type t);
      int k;
      bit ended;
      bit match;
      step_decoded.delete();
      case (t.kind)
         KIND_RESTART: clear_track();
         KIND_TRACK_END: begin
            if (run_mode == MODE_RUN)
               step_decoded.push_back('{byte_acc, 1'b1, STAT_TRACK_END, used_count});
            else if (run_mode == MODE_HUNT)
               step_decoded.push_back(NoSyncEnd);
            clear_track();
         end
         KIND_FLUX: begin
            if (run_mode == MODE_RUN) begin
               place_cells(cells_of(t.flux_interval), ended);
            end else if (run_mode == MODE_HUNT) begin
               for (k = 0; k < HistDepth - 1; k++) hist_cls[k] = hist_cls[k + 1];
               hist_cls[HistDepth - 1] = 2'(cells_of(t.flux_interval) - 1);
               if (hist_seen < HistDepth) hist_seen++;
               if (hist_seen == HistDepth) begin
                  match = 1'b1;
                  for (k = 0; k < SyncLen; k++)
                     if (hist_cls[k + 1] != SyncClass[k]) match = 1'b0;
                  if (match) start_sync_replay();
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got 0x%0h expected 0x%0h at cycle %0d",
               what, got, want, cycle_count);
      mismatches++;
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (pending_decoded.size() == 0) begin
         report_mismatch("unexpected result, data_byte", int'(got.data_byte), 0);
      end else begin
         want = pending_decoded.pop_front();
         if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", int'(got.data_byte), int'(want.data_byte));
         if (got.last !== want.last)
            report_mismatch("last", int'(got.last), int'(want.last));
         if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
         if (got.samples_used !== want.samples_used)
            report_mismatch("samples_used", int'(got.samples_used),
                            int'(want.samples_used));
      end
   endtask

   initial begin : rsp_side
      int gap;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(negedge clock);
            rsp_hold_req = 1'b0;
         end else begin
            gap = rsp_no_gaps ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         check_result(rsp_payload);
      end
   end

   task automatic send_item(input req_payload_type t, input bit typed,
                            input rsp_payload_type want);
      int gap;
      gap = req_no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (req_stall);
      decode_flux(t);
      if (typed) pending_decoded.push_back(want);
      else foreach (step_decoded[i]) pending_decoded.push_back(step_decoded[i]);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_decoded.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] mid_thr, input logic [15:0] long_thr,
                             input logic [15:0] max_b);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MID_THRESHOLD;
      csr_wdata    <= mid_thr;
      @(negedge clock);
      csr_index    <= CSR_LONG_THRESHOLD;
      csr_wdata    <= long_thr;
      @(negedge clock);
      csr_index    <= CSR_MAX_BYTES;
      csr_wdata    <= max_b;
      @(negedge clock);
      csr_write_en <= 1'b0;
      thr_cfg = '{mid_thr, long_thr, max_b};
   endtask

   function automatic logic [15:0] flux_for_cells(input int cells);
      int lo;
      int hi;
      int m;
      int l;
      m = int'(thr_cfg.mid_threshold);
      l = int'(thr_cfg.long_threshold);
      if (cells == 4) begin
         lo = l + 1;
         hi = 65535;
      end else if (cells == 3) begin
         lo = m + 1;
         hi = l;
      end else begin
         lo = 0;
         hi = (m < l) ? m : l;
      end
      if (lo > hi) return 16'($urandom);
      return 16'($urandom_range(hi, lo));
   endfunction

   function automatic logic [15:0] any_flux();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return flux_for_cells($urandom_range(2, 4));
         2: return $urandom_range(0, 1) ?
                   thr_cfg.mid_threshold + 16'($urandom_range(0, 1)) :
                   thr_cfg.long_threshold + 16'($urandom_range(0, 1));
         default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   task automatic push_item(input logic [1:0] kind, input logic [15:0] flux);
      req_payload_type t;
      t.kind          = kind;
      t.flux_interval = flux;
      flux_items.push_back(t);
      if (kind != KindUnused) flux_item_count++;
   endtask

   task automatic push_sync_word(input int upto);
      int k;
      for (k = 0; k < upto; k++) push_item(KIND_FLUX, flux_for_cells(int'(SyncClass[k]) + 1));
   endtask

   task automatic add_sync_run();
      int r;
      if ($urandom_range(0, 4) == 0) push_item(KIND_RESTART, 16'($urandom));
      repeat ($urandom_range(1, 2)) push_item(KIND_FLUX, any_flux());
      push_sync_word(SyncLen);
      repeat ($urandom_range(0, 2))
         push_item(($urandom_range(0, 15) == 0) ? KindUnused : KIND_FLUX, any_flux());
      r = $urandom_range(0, 9);
      if (r < 5) push_item(KIND_TRACK_END, 16'($urandom));
      else if (r < 7) push_item(KIND_RESTART, 16'($urandom));
   endtask

   task automatic add_noise();
      int n;
      int good;
      int bad;
      if ($urandom_range(0, 1)) begin
         n    = $urandom_range(1, SyncLen - 1);
         push_sync_word(n);
         good = int'(SyncClass[n]) + 1;
         if (good == 2) bad = $urandom_range(3, 4);
         else if (good == 4) bad = $urandom_range(2, 3);
         else bad = $urandom_range(0, 1) ? 2 : 4;
         push_item(KIND_FLUX, flux_for_cells(bad));
      end else begin
         push_item(2'($urandom_range(0, 3)), 16'($urandom));
      end
   endtask

   task automatic send_flux_items();
      while (flux_items.size() != 0) send_item(flux_items.pop_front(), 1'b0, NoCheck);
      flux_item_count = 0;
   endtask

   task automatic run_phase(input logic [15:0] mid_thr, input logic [15:0] long_thr,
                            input logic [15:0] max_b, input int count);
      set_config(mid_thr, long_thr, max_b);
      add_sync_run();
      while (flux_item_count < count) begin
         if ($urandom_range(0, 9) < 7) add_sync_run();
         else add_noise();
      end
      send_flux_items();
      settle();
   endtask

   initial begin : stimulus
      int i;
      int mid_r;
      req_payload_type t;
      thr_cfg         = '{MidThreshReset, LongThreshReset, MaxBytesReset};
      flux_item_count = 0;
      clear_track();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < NumDirected; i++) begin
         t.kind          = DirectedRows[i].kind;
         t.flux_interval = DirectedRows[i].flux;
         send_item(t, DirectedRows[i].typed, DirectedRows[i].want);
      end
      settle();

      run_phase(16'd0, 16'd1, 16'd65535, 18);
      req_no_gaps = 1'b1;
      rsp_no_gaps = 1'b1;
      run_phase(16'd65533, 16'd65534, 16'd40, 1);
      req_no_gaps = 1'b0;
      rsp_no_gaps = 1'b0;
      run_phase(16'd65535, 16'd0, 16'd200, 1);
      run_phase(16'd0, 16'd65535, 16'd100, 1);
      run_phase(MidThreshReset, LongThreshReset, 16'd0, 1);
      run_phase(MidThreshReset, LongThreshReset, 16'd1, 1);
      mid_r = $urandom_range(100, 400);
      run_phase(16'(mid_r), 16'(mid_r + $urandom_range(1, 300)), 16'd3, 1);

      set_config(MidThreshReset, LongThreshReset, 16'd65535);
      push_item(KIND_RESTART, 16'd0);
      push_item(KIND_FLUX, any_flux());
      push_sync_word(SyncLen);
      repeat (8) push_item(KIND_FLUX, flux_for_cells(4));
      push_item(KIND_TRACK_END, 16'd0);
      rsp_hold_req = 1'b1;
      req_no_gaps  = 1'b1;
      send_flux_items();
      req_no_gaps  = 1'b0;
      settle();

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
